@@ rtl/ptd_pkg.sv @@
// Shared constants, action codes and request types of the periodic task dispatcher.
package ptd_pkg;

    // Table and field sizes
    localparam int TASK_SLOTS = 8;
    localparam int ACT_W      = 3;
    localparam int SLOT_W     = 3;
    localparam int PERIOD_W   = 16;
    localparam int TICK_W     = 16;
    localparam int SIDX_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int SCNT_W     = $clog2(TASK_SLOTS + 1);

    // Stream widths
    localparam int S_TDATA_W  = ((SLOT_W + PERIOD_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((SLOT_W + 7) / 8) * 8;

    // Request queue between front and back
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Remainder unit step counter
    localparam int MOD_STEP_W = $clog2(TICK_W);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SUSPEND = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RESUME  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_KILL    = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
    } t_req;

    typedef struct packed {
        logic                start;
        logic [TICK_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_rsp;

endpackage

@@ rtl/periodic_task_dispatcher.sv @@
// Top level of the periodic task dispatcher: front queue, back sequencer, remainder unit.
//
// Requests arrive on the s_axis channel: tuser carries the action (tick, create,
// suspend, resume, kill) and tdata the slot and the period. Edits change the task
// table and give no output; a tick advances the 16-bit tick count and then sends
// on m_axis, in slot order, every present, unsuspended slot with a nonzero period
// that divides the count, with tlast on the final one of that tick.
// A two-entry request queue sits between the front end and the back end, so the
// front keeps taking requests while the back is busy or the output is stalled.
// In the back end a tick walks the slots in order, passing over idle ones and running
// the remainder unit on each eligible slot (one bit per cycle over 16 bits), and then
// walks the slots again up to the last due one while the results go out.
// Reset clears the tick count, all present and suspended marks and the queue.
// When the receiver holds tready low the result holds in the output register,
// the back end waits, and once the queue fills s_axis tready drops.
module periodic_task_dispatcher
    import ptd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // slot, period
    input  logic [ACT_W-1:0]     i_s_axis_tuser,   // action
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // task_slot
    output logic                 o_m_axis_tlast    // last
);

    logic     w_req_valid;
    t_req     w_req;
    logic     w_req_pop;
    t_mod_req w_mod_req;
    t_mod_rsp w_mod_rsp;

    ptd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_req_valid     (w_req_valid),
        .o_req           (w_req),
        .i_req_pop       (w_req_pop)
    );

    ptd_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    ptd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (w_req_valid),
        .i_req           (w_req),
        .o_req_pop       (w_req_pop),
        .o_mod_req       (w_mod_req),
        .i_mod_rsp       (w_mod_rsp),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // An empty queue always has room for a request
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_req_valid |-> o_s_axis_tready)
        else $error("queue empty but not ready");

    // The remainder unit cannot finish right after a start
    a_mod_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_req.start |=> !w_mod_rsp.done)
        else $error("remainder done too early");

    // Done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_rsp.done |=> !w_mod_rsp.done)
        else $error("remainder done held");

    // Only slots of the table are sent
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(o_m_axis_tdata[SLOT_W-1:0]) < TASK_SLOTS))
        else $error("task slot beyond table");

endmodule

@@ rtl/ptd_front.sv @@
// Front end: accepts requests, drops those with no effect, and queues the rest.
module ptd_front
    import ptd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // slot, period
    input  logic [ACT_W-1:0]     i_s_axis_tuser,  // action
    output logic                 o_req_valid,
    output t_req                 o_req,
    input  logic                 i_req_pop
);

    t_req               r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;

    logic [SLOT_W-1:0]   w_slot;
    logic [PERIOD_W-1:0] w_period;
    logic                w_is_tick;
    logic                w_is_edit;
    logic                w_slot_ok;
    logic                w_keep;
    logic                w_push;

    // Classify the incoming request
    assign w_slot    = i_s_axis_tdata[SLOT_W-1:0];
    assign w_period  = i_s_axis_tdata[SLOT_W +: PERIOD_W];
    assign w_is_tick = (i_s_axis_tuser == ACT_TICK);
    assign w_is_edit = i_s_axis_tuser inside {ACT_CREATE, ACT_SUSPEND, ACT_RESUME, ACT_KILL};
    assign w_slot_ok = (32'(w_slot) < TASK_SLOTS);
    assign w_keep    = w_is_tick || (w_is_edit && w_slot_ok);

    assign o_s_axis_tready = (r_cnt != QCNT_W'(QDEPTH));
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready && w_keep;

    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rd];

    // Store queued requests
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{action: i_s_axis_tuser, slot: w_slot, period: w_period};
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_req_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !i_req_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_req_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/ptd_mod.sv @@
// Iterative remainder unit: one restoring step per cycle, reports a zero remainder.
module ptd_mod
    import ptd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [MOD_STEP_W-1:0] r_step;
    logic [TICK_W-1:0]     r_num;
    logic [PERIOD_W-1:0]   r_rem;
    logic [PERIOD_W-1:0]   r_div;

    logic [PERIOD_W:0]     w_shift;
    logic [PERIOD_W:0]     w_sub;
    logic                  w_ge;

    // Shift in the next dividend bit and subtract when it fits
    assign w_shift = {r_rem, r_num[TICK_W-1]};
    assign w_sub   = w_shift - {1'b0, r_div};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= {r_num[TICK_W-2:0], 1'b0};
            r_rem <= w_ge ? w_sub[PERIOD_W-1:0] : w_shift[PERIOD_W-1:0];
        end
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == MOD_STEP_W'(TICK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/ptd_back.sv @@
// Back end: applies slot edits, walks the table on a tick, and sends due slots.
module ptd_back
    import ptd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  t_req                 i_req,
    output logic                 o_req_pop,
    output t_mod_req             o_mod_req,
    input  t_mod_rsp             i_mod_rsp,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // task_slot
    output logic                 o_m_axis_tlast   // last
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SCAN = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_EMIT = 2'd3;

    logic [1:0]            r_state,     n_state;
    logic [TICK_W-1:0]     r_tick,      n_tick;
    logic [TASK_SLOTS-1:0] r_present,   n_present;
    logic [TASK_SLOTS-1:0] r_susp,      n_susp;
    logic [TASK_SLOTS-1:0] r_due,       n_due;
    logic [SCNT_W-1:0]     r_idx,       n_idx;
    logic                  r_mod_start, n_mod_start;
    logic                  r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]     r_out_slot,  n_out_slot;
    logic                  r_out_last,  n_out_last;
    logic [PERIOD_W-1:0]   r_period [TASK_SLOTS];

    logic [SIDX_W-1:0]     w_idx;
    logic [SIDX_W-1:0]     w_req_idx;
    logic [TASK_SLOTS-1:0] w_due_rest;
    logic                  w_out_free;
    logic                  w_per_we;

    assign w_idx      = r_idx[SIDX_W-1:0];
    assign w_req_idx  = SIDX_W'(i_req.slot);
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_due_rest = r_due & ~(TASK_SLOTS'(1) << w_idx);

    assign o_mod_req.start    = r_mod_start;
    assign o_mod_req.dividend = r_tick;
    assign o_mod_req.divisor  = r_period[w_idx];

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - SLOT_W){1'b0}}, r_out_slot};
    assign o_m_axis_tlast  = r_out_last;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_present   = r_present;
        n_susp      = r_susp;
        n_due       = r_due;
        n_idx       = r_idx;
        n_mod_start = 1'b0;
        n_out_valid = r_out_valid;
        n_out_slot  = r_out_slot;
        n_out_last  = r_out_last;
        o_req_pop   = 1'b0;
        w_per_we    = 1'b0;

        // Drop the output once taken
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    case (i_req.action)
                        ACT_TICK: begin
                            n_tick  = r_tick + 1'b1;
                            n_idx   = '0;
                            n_due   = '0;
                            n_state = B_SCAN;
                        end
                        ACT_CREATE: begin
                            w_per_we             = 1'b1;
                            n_present[w_req_idx] = 1'b1;
                            n_susp[w_req_idx]    = 1'b0;
                        end
                        ACT_SUSPEND: n_susp[w_req_idx]    = 1'b1;
                        ACT_RESUME:  n_susp[w_req_idx]    = 1'b0;
                        ACT_KILL:    n_present[w_req_idx] = 1'b0;
                        default: ;
                    endcase
                end
            end
            B_SCAN: begin
                if (r_idx == SCNT_W'(TASK_SLOTS)) begin
                    n_idx   = '0;
                    n_state = B_EMIT;
                end else if (r_present[w_idx] && !r_susp[w_idx] && (r_period[w_idx] != '0)) begin
                    n_mod_start = 1'b1;
                    n_state     = B_DIV;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            B_DIV: begin
                if (i_mod_rsp.done) begin
                    n_due[w_idx] = i_mod_rsp.zero;
                    n_idx        = r_idx + 1'b1;
                    n_state      = B_SCAN;
                end
            end
            B_EMIT: begin
                if (r_due == '0) begin
                    n_state = B_IDLE;
                end else if (!r_due[w_idx]) begin
                    n_idx = r_idx + 1'b1;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = SLOT_W'(w_idx);
                    n_out_last  = (w_due_rest == '0);
                    n_due       = w_due_rest;
                    n_idx       = r_idx + 1'b1;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Period table
    always_ff @(posedge i_clk) begin
        if (w_per_we) begin
            r_period[w_req_idx] <= i_req.period;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_slot <= n_out_slot;
        r_out_last <= n_out_last;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_tick      <= '0;
            r_present   <= '0;
            r_susp      <= '0;
            r_due       <= '0;
            r_idx       <= '0;
            r_mod_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_present   <= n_present;
            r_susp      <= n_susp;
            r_due       <= n_due;
            r_idx       <= n_idx;
            r_mod_start <= n_mod_start;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
